FILE: design/vn4_pkg.sv
package vn4_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int AW         = $clog2(TABLE_SIZE);
  localparam int FRAC_BITS  = 16;
  localparam int VALUE_BITS = 16;
  localparam int CW         = 32;

  // pipeline depth from input register to last blend stage
  localparam int NSTG = 9;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_WR_VAL = 2'd1;
  localparam logic [1:0] MODE_WR_PRM = 2'd2;

  typedef logic [AW-1:0]                idx_t;
  typedef logic [FRAC_BITS-1:0]         frac_t;
  typedef logic signed [VALUE_BITS-1:0] val_t;

  // what kind of transaction sits in a stage
  typedef struct packed {
    logic smp;
    logic wv;
    logic wp;
  } ctrl_t;

  typedef struct packed {
    idx_t  ix;
    idx_t  iy;
    idx_t  iz;
    idx_t  it;
    frac_t fx;
    frac_t fy;
    frac_t fz;
    frac_t ft;
    idx_t  widx;
    val_t  wdat;
  } stage_t;

  // a + floor((b - a) * f / 2^FRAC_BITS); stays between a and b
  function automatic val_t lerp(input val_t a, input val_t b, input frac_t f);
    logic signed [VALUE_BITS:0]           diff;
    logic signed [VALUE_BITS+FRAC_BITS+1:0] prod;
    logic signed [VALUE_BITS+FRAC_BITS+1:0] shf;
    logic signed [VALUE_BITS:0]           sum;
    diff = {b[VALUE_BITS-1], b} - {a[VALUE_BITS-1], a};
    prod = diff * $signed({1'b0, f});
    shf  = prod >>> FRAC_BITS;
    sum  = {a[VALUE_BITS-1], a} + shf[VALUE_BITS:0];
    return sum[VALUE_BITS-1:0];
  endfunction

endpackage

FILE: design/vn4_ram.sv
module vn4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/value_noise_4d.sv
// 4D lattice value noise. A transaction is accepted on any clock edge with
// start high; busy is always low, so one transaction per cycle is sustained.
// Mode 0 samples: four signed Q16.16 coordinates in, one signed Q1.15 value
// out on out_noise_out with out_valid high for one cycle; results come out
// in acceptance order. Mode 1 writes a value table entry, mode 2 a
// permutation entry (low byte of in_table_data); mode 3 is dropped. Writes
// give no result. Both tables must be loaded before sampling; they come up
// undefined. The receiver cannot stall: results must be taken when strobed.
// Pipeline: input register, four levels of permutation lookups (t, z, y, x
// hash levels: 2, 4, 8 and 16 RAM copies), 16 value RAM copies, then four
// interpolation stages (x, y, z, t) with one 17x17 multiply per blend each.
// Each table level has its own RAM copies, written when a write transaction
// passes that level, so reads and writes keep transaction order.
module value_noise_4d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic signed [31:0] in_coord_t,
  input  logic [7:0]  in_table_index,
  input  logic signed [15:0] in_table_data,
  output logic        out_valid,
  output logic signed [15:0] out_noise_out
);

  localparam int FB = vn4_pkg::FRAC_BITS;
  localparam int AW = vn4_pkg::AW;

  // control bits per stage (reset), payload per stage (no reset)
  vn4_pkg::ctrl_t  ctl_r [vn4_pkg::NSTG];
  vn4_pkg::stage_t stg_r [vn4_pkg::NSTG];
  vn4_pkg::ctrl_t  ctl_nxt;
  vn4_pkg::stage_t stg_nxt;

  // lookup results, aligned with the following stage
  vn4_pkg::idx_t pt [2];
  vn4_pkg::idx_t pz [4];
  vn4_pkg::idx_t py [8];
  vn4_pkg::idx_t px [16];
  vn4_pkg::val_t vv [16];

  // blend registers
  vn4_pkg::val_t bx_r [8];
  vn4_pkg::val_t by_r [4];
  vn4_pkg::val_t bz_r [2];
  logic          ov_r;
  vn4_pkg::val_t on_r;

  assign busy = 1'b0;

  always_comb begin
    ctl_nxt.smp = start && (in_mode == vn4_pkg::MODE_SAMPLE);
    ctl_nxt.wv  = start && (in_mode == vn4_pkg::MODE_WR_VAL);
    ctl_nxt.wp  = start && (in_mode == vn4_pkg::MODE_WR_PRM);
    // integer part mod table size is just the low bits above the fraction
    stg_nxt.ix   = in_coord_x[FB+AW-1:FB];
    stg_nxt.iy   = in_coord_y[FB+AW-1:FB];
    stg_nxt.iz   = in_coord_z[FB+AW-1:FB];
    stg_nxt.it   = in_coord_t[FB+AW-1:FB];
    stg_nxt.fx   = in_coord_x[FB-1:0];
    stg_nxt.fy   = in_coord_y[FB-1:0];
    stg_nxt.fz   = in_coord_z[FB-1:0];
    stg_nxt.ft   = in_coord_t[FB-1:0];
    stg_nxt.widx = in_table_index[AW-1:0];
    stg_nxt.wdat = in_table_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < vn4_pkg::NSTG; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r[0] <= ctl_nxt;
      for (int k = 1; k < vn4_pkg::NSTG; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_r[0] <= stg_nxt;
    for (int k = 1; k < vn4_pkg::NSTG; k++) begin
      stg_r[k] <= stg_r[k-1];
    end
  end

  // hash level t: perm[it + dt]
  for (genvar g = 0; g < 2; g++) begin : g_pt
    vn4_ram #(.WIDTH(AW), .DEPTH(vn4_pkg::TABLE_SIZE)) u_ram (
      .clk   (clk),
      .we    (ctl_r[0].wp),
      .waddr (stg_r[0].widx),
      .wdata (stg_r[0].wdat[AW-1:0]),
      .raddr (stg_r[0].it + AW'(g)),
      .rdata (pt[g])
    );
  end

  // hash level z: perm[iz + dz + pt[dt]], index {dt,dz}
  for (genvar g = 0; g < 4; g++) begin : g_pz
    vn4_ram #(.WIDTH(AW), .DEPTH(vn4_pkg::TABLE_SIZE)) u_ram (
      .clk   (clk),
      .we    (ctl_r[1].wp),
      .waddr (stg_r[1].widx),
      .wdata (stg_r[1].wdat[AW-1:0]),
      .raddr (stg_r[1].iz + AW'(g % 2) + pt[g/2]),
      .rdata (pz[g])
    );
  end

  // hash level y, index {dt,dz,dy}
  for (genvar g = 0; g < 8; g++) begin : g_py
    vn4_ram #(.WIDTH(AW), .DEPTH(vn4_pkg::TABLE_SIZE)) u_ram (
      .clk   (clk),
      .we    (ctl_r[2].wp),
      .waddr (stg_r[2].widx),
      .wdata (stg_r[2].wdat[AW-1:0]),
      .raddr (stg_r[2].iy + AW'(g % 2) + pz[g/2]),
      .rdata (py[g])
    );
  end

  // hash level x, index {dt,dz,dy,dx}
  for (genvar g = 0; g < 16; g++) begin : g_px
    vn4_ram #(.WIDTH(AW), .DEPTH(vn4_pkg::TABLE_SIZE)) u_ram (
      .clk   (clk),
      .we    (ctl_r[3].wp),
      .waddr (stg_r[3].widx),
      .wdata (stg_r[3].wdat[AW-1:0]),
      .raddr (stg_r[3].ix + AW'(g % 2) + py[g/2]),
      .rdata (px[g])
    );
  end

  // corner values
  for (genvar g = 0; g < 16; g++) begin : g_val
    vn4_ram #(.WIDTH(vn4_pkg::VALUE_BITS), .DEPTH(vn4_pkg::TABLE_SIZE)) u_ram (
      .clk   (clk),
      .we    (ctl_r[4].wv),
      .waddr (stg_r[4].widx),
      .wdata (stg_r[4].wdat),
      .raddr (px[g]),
      .rdata (vv[g])
    );
  end

  // blends: x at stage 5, y at 6, z at 7, t at 8
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      bx_r[i] <= vn4_pkg::lerp(vv[2*i], vv[2*i+1], stg_r[5].fx);
    end
    for (int i = 0; i < 4; i++) begin
      by_r[i] <= vn4_pkg::lerp(bx_r[2*i], bx_r[2*i+1], stg_r[6].fy);
    end
    for (int i = 0; i < 2; i++) begin
      bz_r[i] <= vn4_pkg::lerp(by_r[2*i], by_r[2*i+1], stg_r[7].fz);
    end
    on_r <= vn4_pkg::lerp(bz_r[0], bz_r[1], stg_r[8].ft);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ctl_r[8].smp;
    end
  end

  assign out_valid     = ov_r;
  assign out_noise_out = on_r;

endmodule
